>>> rtl/tjg_pkg.sv
// tjg_pkg: shared constants, types and helpers for the touch joystick gesture tracker
// no dependencies; imported by tjg_front, tjg_engine and the top level
package tjg_pkg;

  // table and field sizes
  localparam int MAX_FINGERS = 8;
  localparam int COORD_BITS  = 16;
  localparam int SLOT_W      = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
  localparam int ID_W        = 8;
  localparam int STAMP_W     = 32;
  localparam int LIMIT_W     = 16;
  localparam int OPC_W       = 3;
  localparam int OUT_COORD_W = 16;
  localparam int IN_COORD_W  = 16;
  localparam int RSTATE_W    = 3;
  localparam int KIND_W      = 2;

  // squared distance compare widths
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int LIM_SQ_W = 2 * LIMIT_W;
  localparam int CMP_W    = ((SQ_W > LIM_SQ_W) ? SQ_W : LIM_SQ_W) + 1;

  // item queue between front and engine
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 1'b1;

  // result codes
  localparam logic [RSTATE_W-1:0] RS_FAILED  = 3'd0;
  localparam logic [RSTATE_W-1:0] RS_RECOG   = 3'd1;
  localparam logic [RSTATE_W-1:0] RS_READY   = 3'd2;
  localparam logic [RSTATE_W-1:0] RS_HOLD    = 3'd3;
  localparam logic [RSTATE_W-1:0] RS_DONE    = 3'd4;

  localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] EV_MOVE  = 2'd1;
  localparam logic [KIND_W-1:0] EV_RESET = 2'd2;

  typedef enum logic [OPC_W-1:0] {
    OP_DOWN   = 3'd0,
    OP_MOTION = 3'd1,
    OP_UP     = 3'd2,
    OP_DETACH = 3'd3,
    OP_FETCH  = 3'd4,
    OP_QUERY  = 3'd5,
    OP_TICK   = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    PH_CAND       = 3'd0,
    PH_MOVE_RDY   = 3'd1,
    PH_RESET_RDY  = 3'd2,
    PH_MOVED      = 3'd3,
    PH_RESET_DONE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_LOOKUP,
    ENG_READ,
    ENG_MUL,
    ENG_EXEC,
    ENG_SCAN
  } eng_state_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    op_t                op;
    logic [ID_W-1:0]    finger_id;
    coord_t             pos_x;
    coord_t             pos_y;
    logic [STAMP_W-1:0] stamp_ms;
  } item_t;

  // front to engine: head of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] time_limit_ms;
    logic [LIMIT_W-1:0] distance_limit;
  } cfg_t;

  function automatic logic [RSTATE_W-1:0] phase_state(input phase_t ph);
    logic [RSTATE_W-1:0] st;
    unique case (ph)
      PH_CAND:       st = RS_RECOG;
      PH_MOVE_RDY:   st = RS_READY;
      PH_RESET_RDY:  st = RS_READY;
      PH_MOVED:      st = RS_HOLD;
      PH_RESET_DONE: st = RS_DONE;
      default:       st = RS_FAILED;
    endcase
    return st;
  endfunction

endpackage

>>> rtl/tjg_front.sv
// tjg_front: command intake, opcode classification and a short item queue
// depends on tjg_pkg
module tjg_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tjg_pkg::OPC_W-1:0]         in_opcode,
  input  logic [tjg_pkg::ID_W-1:0]          in_finger_id,
  input  logic [tjg_pkg::IN_COORD_W-1:0]    in_pos_x,
  input  logic [tjg_pkg::IN_COORD_W-1:0]    in_pos_y,
  input  logic [tjg_pkg::STAMP_W-1:0]       in_stamp_ms,
  input  logic                              q_pop,
  output tjg_pkg::q_head_t                  q_head
);
  import tjg_pkg::*;

  item_t              q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push;
  logic               pop;
  item_t              new_item;

  // classify the command and trim coordinates to the kept width
  always_comb begin
    new_item.op        = op_t'(in_opcode);
    new_item.finger_id = in_finger_id;
    new_item.pos_x     = COORD_BITS'(in_pos_x);
    new_item.pos_y     = COORD_BITS'(in_pos_y);
    new_item.stamp_ms  = in_stamp_ms;
  end

  assign busy = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push = start && !busy;
  assign pop  = q_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = q_mem[rd_ptr_r];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("item queue count beyond depth");
`endif

endmodule

>>> rtl/tjg_engine.sv
// tjg_engine: finger slot table and sequenced execution of one item at a time
// depends on tjg_pkg; fed by tjg_front through the item queue
module tjg_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tjg_pkg::cfg_t                      cfg,
  input  tjg_pkg::q_head_t                   q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  output logic [tjg_pkg::RSTATE_W-1:0]       out_recog_state,
  output logic [tjg_pkg::KIND_W-1:0]         out_event_kind,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_start_x,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_start_y,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_end_x,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_end_y,
  output logic                               out_error_flag
);
  import tjg_pkg::*;

  eng_state_t state_r, state_nxt;

  // slot table
  logic               used_r   [MAX_FINGERS];
  logic [ID_W-1:0]    finger_r [MAX_FINGERS];
  phase_t             phase_r  [MAX_FINGERS];
  coord_t             ox_r     [MAX_FINGERS];
  coord_t             oy_r     [MAX_FINGERS];
  logic [STAMP_W-1:0] ot_r     [MAX_FINGERS];
  coord_t             lx_r     [MAX_FINGERS];
  coord_t             ly_r     [MAX_FINGERS];

  // item in work
  item_t              item_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               hit_r;
  logic               free_ok_r;
  phase_t             ph_r;
  coord_t             org_x_r, org_y_r, lat_x_r, lat_y_r;
  coord_t             dx_r, dy_r;
  logic [STAMP_W-1:0] elapsed_r;
  logic [SQ_W-1:0]    dx2_r, dy2_r;
  logic [LIM_SQ_W-1:0] lim2_r;
  logic               tout_r;
  logic [SLOT_W-1:0]  scan_idx_r;

  // registered result
  logic                   out_valid_r;
  logic [RSTATE_W-1:0]    out_st_r;
  logic [KIND_W-1:0]      out_kind_r;
  coord_t                 out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic                   out_err_r;

  // lookup
  logic               hit_c, free_c;
  logic [SLOT_W-1:0]  hit_idx_c, free_idx_c;

  // single read index into the table, shared by the read step and the scan
  logic [SLOT_W-1:0]  rd_idx;
  logic [STAMP_W-1:0] rd_elapsed;
  logic               scan_kill;
  logic               scan_last;

  // execute decisions
  logic               far_c;
  logic               wr_entry, clr_used, set_phase, upd_latest;
  phase_t             new_phase;
  logic [RSTATE_W-1:0] st_c;
  logic [KIND_W-1:0]  kind_c;
  coord_t             sx_c, sy_c, ex_c, ey_c;
  logic               err_c;

  // controls
  logic               do_pop, do_lookup, do_read, do_mul, do_exec, do_scan;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (q_head.valid) begin
          state_nxt = (q_head.item.op == OP_TICK) ? ENG_SCAN : ENG_LOOKUP;
        end
      end
      ENG_LOOKUP: state_nxt = ENG_READ;
      ENG_READ:   state_nxt = ENG_MUL;
      ENG_MUL:    state_nxt = ENG_EXEC;
      ENG_EXEC:   state_nxt = ENG_IDLE;
      ENG_SCAN: begin
        if (scan_last) begin
          state_nxt = ENG_EXEC;
        end
      end
      default:    state_nxt = ENG_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    do_pop    = 1'b0;
    do_lookup = 1'b0;
    do_read   = 1'b0;
    do_mul    = 1'b0;
    do_exec   = 1'b0;
    do_scan   = 1'b0;
    unique case (state_r)
      ENG_IDLE:   do_pop    = q_head.valid;
      ENG_LOOKUP: do_lookup = 1'b1;
      ENG_READ:   do_read   = 1'b1;
      ENG_MUL:    do_mul    = 1'b1;
      ENG_EXEC:   do_exec   = 1'b1;
      ENG_SCAN:   do_scan   = 1'b1;
      default:    do_pop    = 1'b0;
    endcase
  end

  assign q_pop = do_pop;

  // id match and first free slot, lowest index wins
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = MAX_FINGERS - 1; i >= 0; i--) begin
      if (used_r[i] && (finger_r[i] == item_r.finger_id)) begin
        hit_c     = 1'b1;
        hit_idx_c = SLOT_W'(i);
      end
      if (!used_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = SLOT_W'(i);
      end
    end
  end

  assign rd_idx     = do_scan ? scan_idx_r : slot_r;
  assign rd_elapsed = item_r.stamp_ms - ot_r[rd_idx];
  assign scan_last  = (scan_idx_r == SLOT_W'(MAX_FINGERS - 1));
  assign scan_kill  = do_scan && used_r[rd_idx] && (phase_r[rd_idx] == PH_CAND) &&
                      (rd_elapsed > STAMP_W'(cfg.time_limit_ms));

  assign far_c = (CMP_W'(dx2_r) + CMP_W'(dy2_r)) >= CMP_W'(lim2_r);

  // execute step
  always_comb begin
    wr_entry   = 1'b0;
    clr_used   = 1'b0;
    set_phase  = 1'b0;
    upd_latest = 1'b0;
    new_phase  = PH_CAND;
    st_c       = RS_FAILED;
    kind_c     = EV_NONE;
    sx_c       = '0;
    sy_c       = '0;
    ex_c       = '0;
    ey_c       = '0;
    err_c      = 1'b0;
    unique case (item_r.op)
      OP_DOWN: begin
        if (hit_r || free_ok_r) begin
          wr_entry  = 1'b1;
          set_phase = 1'b1;
          new_phase = ((cfg.time_limit_ms == '0) || (cfg.distance_limit == '0)) ?
                      PH_MOVE_RDY : PH_CAND;
          st_c      = phase_state(new_phase);
        end else begin
          err_c = 1'b1;
        end
      end
      OP_MOTION: begin
        if (hit_r) begin
          priority if (ph_r == PH_CAND && tout_r) begin
            clr_used = 1'b1;
          end else if (ph_r == PH_CAND && !far_c) begin
            st_c = RS_RECOG;
          end else begin
            upd_latest = 1'b1;
            set_phase  = 1'b1;
            new_phase  = PH_MOVE_RDY;
            st_c       = RS_READY;
          end
        end
      end
      OP_UP: begin
        if (hit_r && ph_r != PH_CAND) begin
          upd_latest = 1'b1;
          set_phase  = 1'b1;
          new_phase  = PH_RESET_RDY;
          st_c       = RS_READY;
        end
      end
      OP_DETACH: begin
        clr_used = hit_r;
      end
      OP_FETCH: begin
        priority if (hit_r && ph_r == PH_MOVE_RDY) begin
          set_phase = 1'b1;
          new_phase = PH_MOVED;
          kind_c    = EV_MOVE;
          sx_c      = org_x_r;
          sy_c      = org_y_r;
          ex_c      = lat_x_r;
          ey_c      = lat_y_r;
          st_c      = RS_HOLD;
        end else if (hit_r && ph_r == PH_RESET_RDY) begin
          set_phase = 1'b1;
          new_phase = PH_RESET_DONE;
          kind_c    = EV_RESET;
          ex_c      = lat_x_r;
          ey_c      = lat_y_r;
          st_c      = RS_DONE;
        end else begin
          err_c = 1'b1;
          st_c  = hit_r ? phase_state(ph_r) : RS_FAILED;
        end
      end
      OP_QUERY: begin
        st_c = hit_r ? phase_state(ph_r) : RS_FAILED;
      end
      OP_TICK: begin
        st_c = RS_FAILED;
      end
      default: begin
        st_c = RS_FAILED;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      out_valid_r <= 1'b0;
      scan_idx_r  <= '0;
      for (int i = 0; i < MAX_FINGERS; i++) begin
        used_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= do_exec;
      if (do_pop) begin
        scan_idx_r <= '0;
      end else if (do_scan && !scan_last) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (scan_kill) begin
        used_r[rd_idx] <= 1'b0;
      end
      if (do_exec && wr_entry) begin
        used_r[slot_r] <= 1'b1;
      end
      if (do_exec && clr_used) begin
        used_r[slot_r] <= 1'b0;
      end
    end
  end

  // datapath and table payload
  always_ff @(posedge clk) begin
    if (do_pop) begin
      item_r <= q_head.item;
    end
    if (do_lookup) begin
      hit_r     <= hit_c;
      free_ok_r <= free_c;
      slot_r    <= hit_c ? hit_idx_c : free_idx_c;
    end
    if (do_read) begin
      ph_r      <= phase_r[rd_idx];
      org_x_r   <= ox_r[rd_idx];
      org_y_r   <= oy_r[rd_idx];
      lat_x_r   <= lx_r[rd_idx];
      lat_y_r   <= ly_r[rd_idx];
      dx_r      <= (item_r.pos_x >= ox_r[rd_idx]) ? item_r.pos_x - ox_r[rd_idx]
                                                  : ox_r[rd_idx] - item_r.pos_x;
      dy_r      <= (item_r.pos_y >= oy_r[rd_idx]) ? item_r.pos_y - oy_r[rd_idx]
                                                  : oy_r[rd_idx] - item_r.pos_y;
      elapsed_r <= rd_elapsed;
    end
    if (do_mul) begin
      dx2_r  <= SQ_W'(dx_r) * SQ_W'(dx_r);
      dy2_r  <= SQ_W'(dy_r) * SQ_W'(dy_r);
      lim2_r <= LIM_SQ_W'(cfg.distance_limit) * LIM_SQ_W'(cfg.distance_limit);
      tout_r <= elapsed_r > STAMP_W'(cfg.time_limit_ms);
    end
    if (do_exec) begin
      if (wr_entry) begin
        finger_r[slot_r] <= item_r.finger_id;
        ox_r[slot_r]     <= item_r.pos_x;
        oy_r[slot_r]     <= item_r.pos_y;
        ot_r[slot_r]     <= item_r.stamp_ms;
        lx_r[slot_r]     <= item_r.pos_x;
        ly_r[slot_r]     <= item_r.pos_y;
      end
      if (upd_latest) begin
        lx_r[slot_r] <= item_r.pos_x;
        ly_r[slot_r] <= item_r.pos_y;
      end
      if (set_phase) begin
        phase_r[slot_r] <= new_phase;
      end
      out_st_r   <= st_c;
      out_kind_r <= kind_c;
      out_sx_r   <= sx_c;
      out_sy_r   <= sy_c;
      out_ex_r   <= ex_c;
      out_ey_r   <= ey_c;
      out_err_r  <= err_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_recog_state = out_st_r;
  assign out_event_kind  = out_kind_r;
  assign out_start_x     = OUT_COORD_W'(out_sx_r);
  assign out_start_y     = OUT_COORD_W'(out_sy_r);
  assign out_end_x       = OUT_COORD_W'(out_ex_r);
  assign out_end_y       = OUT_COORD_W'(out_ey_r);
  assign out_error_flag  = out_err_r;

`ifndef ASSERT_OFF
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ENG_EXEC))
    else $error("result strobe without an execute step");

  a_err_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (item_r.op == OP_DOWN || item_r.op == OP_FETCH))
    else $error("error flag on an item that cannot fail");

  a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_SCAN && $past(state_r) != ENG_SCAN) |-> (scan_idx_r == '0))
    else $error("slot scan did not start at the first slot");
`endif

endmodule

>>> rtl/touch_joystick_gesture_tracker.sv
// an item goes from the queue through the engine's idle, lookup, read, multiply and execute
// states before its result strobes; a tick goes through idle, a scan of every slot (one
// slot checked per cycle) and execute; the engine takes no new item until it is through
// with the last, and a two-item queue lets new items in while the engine works
// reset clears the queue, the slot-used flags and both limits; no clearing pass is needed
// out_valid marks each result for exactly one cycle; the other out_ ports keep it until the next
module touch_joystick_gesture_tracker (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [tjg_pkg::OPC_W-1:0]          in_opcode,
  input  logic [tjg_pkg::ID_W-1:0]           in_finger_id,
  input  logic [tjg_pkg::IN_COORD_W-1:0]     in_pos_x,
  input  logic [tjg_pkg::IN_COORD_W-1:0]     in_pos_y,
  input  logic [tjg_pkg::STAMP_W-1:0]        in_stamp_ms,
  // result channel
  output logic                               out_valid,
  output logic [tjg_pkg::RSTATE_W-1:0]       out_recog_state,
  output logic [tjg_pkg::KIND_W-1:0]         out_event_kind,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_start_x,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_start_y,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_end_x,
  output logic [tjg_pkg::OUT_COORD_W-1:0]    out_end_y,
  output logic                               out_error_flag,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [tjg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tjg_pkg::LIMIT_W-1:0]        cfg_wdata
);
  import tjg_pkg::*;

  // limit registers, to be written by the user only while the block is idle; the block does not enforce it
  logic [LIMIT_W-1:0] time_limit_r, time_limit_nxt;
  logic [LIMIT_W-1:0] dist_limit_r, dist_limit_nxt;
  cfg_t               cfg;

  // item queue head and pop between front and engine
  q_head_t            q_head;
  logic               q_pop;

  always_comb begin
    time_limit_nxt = time_limit_r;
    dist_limit_nxt = dist_limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_LIMIT: time_limit_nxt = cfg_wdata;
        CFG_DIST_LIMIT: dist_limit_nxt = cfg_wdata;
        default:        time_limit_nxt = time_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_limit_r <= '0;
      dist_limit_r <= '0;
    end else begin
      time_limit_r <= time_limit_nxt;
      dist_limit_r <= dist_limit_nxt;
    end
  end

  assign cfg.time_limit_ms  = time_limit_r;
  assign cfg.distance_limit = dist_limit_r;

  // front: takes commands, classifies them and queues them
  tjg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_finger_id (in_finger_id),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_stamp_ms  (in_stamp_ms),
    .q_pop        (q_pop),
    .q_head       (q_head)
  );

  // engine: slot table, distance and timeout checks, result register
  tjg_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_recog_state (out_recog_state),
    .out_event_kind  (out_event_kind),
    .out_start_x     (out_start_x),
    .out_start_y     (out_start_y),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_error_flag  (out_error_flag)
  );

endmodule

>>> sim/tb_touch_joystick_gesture_tracker.sv
// testbench for the touch joystick gesture tracker: directed finger sequences, then random
// touch traffic under several limit settings, each report checked against a local tracker
// depends on tjg_pkg and touch_joystick_gesture_tracker from the rtl folder
module tb_touch_joystick_gesture_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import tjg_pkg::*;

  localparam int QUIET_LIMIT = 3000;   // cycles with no item and no report before giving up

  // one report of the tracker, as the result ports carry it
  typedef struct packed {
    logic [RSTATE_W-1:0]    recog_state;
    logic [KIND_W-1:0]      event_kind;
    logic [OUT_COORD_W-1:0] start_x;
    logic [OUT_COORD_W-1:0] start_y;
    logic [OUT_COORD_W-1:0] end_x;
    logic [OUT_COORD_W-1:0] end_y;
    logic                   error_flag;
  } touch_report_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [OPC_W-1:0]       in_opcode;
  logic [ID_W-1:0]        in_finger_id;
  logic [IN_COORD_W-1:0]  in_pos_x;
  logic [IN_COORD_W-1:0]  in_pos_y;
  logic [STAMP_W-1:0]     in_stamp_ms;
  logic                   out_valid;
  logic [RSTATE_W-1:0]    out_recog_state;
  logic [KIND_W-1:0]      out_event_kind;
  logic [OUT_COORD_W-1:0] out_start_x;
  logic [OUT_COORD_W-1:0] out_start_y;
  logic [OUT_COORD_W-1:0] out_end_x;
  logic [OUT_COORD_W-1:0] out_end_y;
  logic                   out_error_flag;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [LIMIT_W-1:0]     cfg_wdata;

  touch_joystick_gesture_tracker dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_finger_id    (in_finger_id),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_stamp_ms     (in_stamp_ms),
    .out_valid       (out_valid),
    .out_recog_state (out_recog_state),
    .out_event_kind  (out_event_kind),
    .out_start_x     (out_start_x),
    .out_start_y     (out_start_y),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_error_flag  (out_error_flag),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // local copy of the finger table and the limits
  logic               finger_live [MAX_FINGERS];
  logic [ID_W-1:0]    finger_tag  [MAX_FINGERS];
  phase_t             finger_ph   [MAX_FINGERS];
  coord_t             first_x     [MAX_FINGERS];
  coord_t             first_y     [MAX_FINGERS];
  logic [STAMP_W-1:0] first_ms    [MAX_FINGERS];
  coord_t             last_x      [MAX_FINGERS];
  coord_t             last_y      [MAX_FINGERS];
  logic [LIMIT_W-1:0] wait_limit_ms;
  logic [LIMIT_W-1:0] drag_limit;

  touch_report_t pending_reports[$];
  int            mismatch_count = 0;
  int            reports_checked = 0;
  int            op_seen[8];
  int            limit_settings = 0;
  int            quiet_cycles = 0;
  logic          steady_stream = 1'b0;   // no idle gaps while set
  logic [STAMP_W-1:0] clock_ms;          // running touch time for random traffic

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- tracker prediction

  function automatic int find_finger(input logic [ID_W-1:0] fid);
    for (int i = 0; i < MAX_FINGERS; i++)
      if (finger_live[i] && finger_tag[i] == fid) return i;
    return -1;
  endfunction

  function automatic logic [RSTATE_W-1:0] report_for_phase(input phase_t ph);
    case (ph)
      PH_CAND:                    return RS_RECOG;
      PH_MOVE_RDY, PH_RESET_RDY:  return RS_READY;
      PH_MOVED:                   return RS_HOLD;
      PH_RESET_DONE:              return RS_DONE;
      default:                    return RS_FAILED;
    endcase
  endfunction

  // wrapping elapsed time, strictly over the limit
  function automatic logic candidate_expired(input int s, input logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] elapsed;
    elapsed = now - first_ms[s];
    return elapsed > STAMP_W'(wait_limit_ms);
  endfunction

  // applies one item to the local table and returns the report it should produce
  function automatic touch_report_t apply_touch_op(input op_t op, input logic [ID_W-1:0] fid,
                                                   input coord_t px, input coord_t py,
                                                   input logic [STAMP_W-1:0] now);
    touch_report_t r;
    int s;
    longint unsigned dx, dy, reach_sq;
    r = '0;
    s = find_finger(fid);
    case (op)
      OP_DOWN: begin
        if (s < 0)
          for (int i = MAX_FINGERS - 1; i >= 0; i--)
            if (!finger_live[i]) s = i;
        if (s < 0) begin
          r.error_flag = 1'b1;             // table full, nothing changes
        end else begin
          finger_live[s] = 1'b1;
          finger_tag[s]  = fid;
          first_x[s]     = px;
          first_y[s]     = py;
          first_ms[s]    = now;
          last_x[s]      = px;
          last_y[s]      = py;
          finger_ph[s]   = (wait_limit_ms == 0 || drag_limit == 0) ? PH_MOVE_RDY : PH_CAND;
          r.recog_state  = report_for_phase(finger_ph[s]);
        end
      end
      OP_MOTION: begin
        if (s >= 0) begin
          if (finger_ph[s] != PH_CAND) begin
            last_x[s] = px;
            last_y[s] = py;
            finger_ph[s] = PH_MOVE_RDY;
            r.recog_state = RS_READY;
          end else if (candidate_expired(s, now)) begin
            finger_live[s] = 1'b0;         // candidate fails, report stays failed
          end else begin
            dx = (px > first_x[s]) ? 64'(px - first_x[s]) : 64'(first_x[s] - px);
            dy = (py > first_y[s]) ? 64'(py - first_y[s]) : 64'(first_y[s] - py);
            reach_sq = longint'(drag_limit) * longint'(drag_limit);
            if (dx * dx + dy * dy >= reach_sq) begin
              last_x[s] = px;
              last_y[s] = py;
              finger_ph[s] = PH_MOVE_RDY;
              r.recog_state = RS_READY;
            end else begin
              r.recog_state = RS_RECOG;  // too short yet, latest point kept
            end
          end
        end
      end
      OP_UP: begin
        if (s >= 0 && finger_ph[s] != PH_CAND) begin
          last_x[s] = px;
          last_y[s] = py;
          finger_ph[s] = PH_RESET_RDY;
          r.recog_state = RS_READY;
        end
      end
      OP_DETACH: begin
        if (s >= 0) finger_live[s] = 1'b0;
      end
      OP_FETCH: begin
        if (s >= 0 && finger_ph[s] == PH_MOVE_RDY) begin
          finger_ph[s] = PH_MOVED;
          r.event_kind = EV_MOVE;
          r.start_x = first_x[s];
          r.start_y = first_y[s];
          r.end_x = last_x[s];
          r.end_y = last_y[s];
          r.recog_state = RS_HOLD;
        end else if (s >= 0 && finger_ph[s] == PH_RESET_RDY) begin
          finger_ph[s] = PH_RESET_DONE;
          r.event_kind = EV_RESET;
          r.end_x = last_x[s];
          r.end_y = last_y[s];
          r.recog_state = RS_DONE;
        end else begin
          r.error_flag = 1'b1;
          r.recog_state = (s >= 0) ? report_for_phase(finger_ph[s]) : RS_FAILED;
        end
      end
      OP_QUERY: begin
        r.recog_state = (s >= 0) ? report_for_phase(finger_ph[s]) : RS_FAILED;
      end
      OP_TICK: begin
        for (int i = 0; i < MAX_FINGERS; i++)
          if (finger_live[i] && finger_ph[i] == PH_CAND && candidate_expired(i, now))
            finger_live[i] = 1'b0;
      end
      default: ;                           // unused opcode, all fields zero
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int pick_gap();
    int r;
    if (steady_stream) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);           // occasional long pause
  endfunction

  // sends one item and records the report it should cause
  task automatic send_touch(input op_t op, input logic [ID_W-1:0] fid,
                            input coord_t px, input coord_t py,
                            input logic [STAMP_W-1:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_finger_id <= fid;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_stamp_ms  <= stamp;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_reports.push_back(apply_touch_op(op, fid, px, py, stamp));
    op_seen[op]++;
  endtask

  // stop sending, let every report come back and the engine go quiet
  task automatic drain_and_settle();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (MAX_FINGERS + 6) @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] wait_ms, input logic [LIMIT_W-1:0] drag);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIME_LIMIT;
    cfg_wdata <= wait_ms;
    @(posedge clk);
    wait_limit_ms = wait_ms;
    cfg_index <= CFG_DIST_LIMIT;
    cfg_wdata <= drag;
    @(posedge clk);
    drag_limit = drag;
    cfg_we <= 1'b0;
    limit_settings++;
  endtask

  // ---------------------------------------------------------------- report checking

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t ns %s: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // results are only valid for one cycle, sampled at the edge that ends it
  always @(posedge clk) begin
    touch_report_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t ns unexpected report: expected none, actual state %0h kind %0h",
                 $time, out_recog_state, out_event_kind);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        check_field("recog_state", 32'(want.recog_state), 32'(out_recog_state));
        check_field("event_kind", 32'(want.event_kind), 32'(out_event_kind));
        check_field("start_x", 32'(want.start_x), 32'(out_start_x));
        check_field("start_y", 32'(want.start_y), 32'(out_start_y));
        check_field("end_x", 32'(want.end_x), 32'(out_end_x));
        check_field("end_y", 32'(want.end_y), 32'(out_end_y));
        check_field("error_flag", 32'(want.error_flag), 32'(out_error_flag));
      end
    end
  end

  // watchdog: counts cycles in which neither an item nor a report moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: %0d reports still outstanding", pending_reports.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // both limits zero after reset: every down arms a move at once
  task automatic test_instant_arm();
    send_touch(OP_DOWN, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000);
    send_touch(OP_FETCH, 8'h00, 16'h0000, 16'h0000, 32'h0000_0001);
    send_touch(OP_FETCH, 8'h00, 16'h0000, 16'h0000, 32'h0000_0002); // already held
    send_touch(OP_UP, 8'h00, 16'hFFFF, 16'hFFFF, 32'h0000_0003);
    send_touch(OP_FETCH, 8'h00, 16'h0000, 16'h0000, 32'h0000_0004); // reset event
    send_touch(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 32'h0000_0005);
    send_touch(OP_MOTION, 8'h00, 16'h1234, 16'hABCD, 32'hFFFF_FFFF); // motion after done
    send_touch(OP_FETCH, 8'h00, 16'h0000, 16'h0000, 32'h0000_0006);
    send_touch(OP_DETACH, 8'h00, 16'h0000, 16'h0000, 32'h0000_0007);
  endtask

  // ids that are not in the table, a tick, and the unused opcode
  task automatic test_unknown_fingers();
    send_touch(OP_MOTION, 8'hFF, 16'h5555, 16'hAAAA, 32'h0000_0010);
    send_touch(OP_UP, 8'hFF, 16'hAAAA, 16'h5555, 32'h0000_0011);
    send_touch(OP_DETACH, 8'hFF, 16'h0000, 16'h0000, 32'h0000_0012);
    send_touch(OP_FETCH, 8'hFF, 16'h0000, 16'h0000, 32'h0000_0013);
    send_touch(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 32'h0000_0014); // detached earlier
    send_touch(OP_TICK, 8'h00, 16'h0000, 16'h0000, 32'h8000_0000);
    send_touch(OP_NONE, 8'hA5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // fill every slot, overflow it, then overwrite a known id
  task automatic test_full_table();
    for (int i = 0; i < MAX_FINGERS; i++)
      send_touch(OP_DOWN, 8'(8'h80 + i), 16'(i * 16'h1111), 16'(~(i * 16'h1111)), 32'(i));
    send_touch(OP_DOWN, 8'hFE, 16'h0101, 16'h0202, 32'h0000_0100);
    send_touch(OP_DOWN, 8'h80, 16'h0303, 16'h0404, 32'h0000_0101);
  endtask

  // candidates: short travel, travel exactly on the limit across the time wrap,
  // timeout on motion, up on a candidate, timeout on a tick
  task automatic test_candidate_limits();
    set_limits(16'd100, 16'd1000);
    send_touch(OP_DOWN, 8'h80, 16'd1000, 16'd1000, 32'hFFFF_FFC0);
    send_touch(OP_MOTION, 8'h80, 16'd1999, 16'd1000, 32'hFFFF_FFF0);
    send_touch(OP_MOTION, 8'h80, 16'd2000, 16'd1000, 32'h0000_0024); // 100 ms exactly
    send_touch(OP_FETCH, 8'h80, 16'd0, 16'd0, 32'h0000_0025);
    send_touch(OP_DOWN, 8'h81, 16'd500, 16'd500, 32'h0000_0000);
    send_touch(OP_MOTION, 8'h81, 16'd600, 16'd600, 32'h0000_0065);   // 101 ms, fails
    send_touch(OP_QUERY, 8'h81, 16'd0, 16'd0, 32'h0000_0066);
    send_touch(OP_DOWN, 8'h82, 16'd7, 16'd7, 32'h0000_03E8);
    send_touch(OP_UP, 8'h82, 16'd9, 16'd9, 32'h0000_03E9);
    send_touch(OP_TICK, 8'h00, 16'd0, 16'd0, 32'h0000_044D);
    send_touch(OP_QUERY, 8'h82, 16'd0, 16'd0, 32'h0000_044E);
  endtask

  // moves a coordinate by off in a random direction, saturating at the screen edge
  function automatic coord_t nudge(input coord_t base, input int off);
    int v;
    v = $urandom_range(0, 1) ? int'(base) + off : int'(base) - off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return coord_t'(v);
  endfunction

  // random traffic on a small pool of fingers, so the table fills and empties
  task automatic test_random_limits(input logic [LIMIT_W-1:0] wait_ms,
                                    input logic [LIMIT_W-1:0] drag, input int count);
    int r, s, reach, off_x, off_y;
    op_t op;
    logic [ID_W-1:0] fid;
    coord_t px, py;
    logic [STAMP_W-1:0] stamp;
    set_limits(wait_ms, drag);
    clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 59) == 0) steady_stream = ~steady_stream;
      r = $urandom_range(0, 99);
      if (r < 20)      op = OP_DOWN;
      else if (r < 47) op = OP_MOTION;
      else if (r < 57) op = OP_UP;
      else if (r < 66) op = OP_DETACH;
      else if (r < 82) op = OP_FETCH;
      else if (r < 88) op = OP_QUERY;
      else if (r < 99) op = OP_TICK;
      else             op = OP_NONE;
      fid = ($urandom_range(0, 99) < 88) ? ID_W'(8'h40 + $urandom_range(0, 9)) : ID_W'($urandom);
      // time mostly creeps forward, sometimes jumps, sometimes is arbitrary
      if ($urandom_range(0, 99) < 3) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(0, int'(wait_limit_ms) / 3 + 4);
      stamp = ($urandom_range(0, 99) < 5) ? $urandom : clock_ms;
      s = find_finger(fid);
      if (s < 0 || $urandom_range(0, 9) == 0) begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end else begin
        // travel around the drag limit, sometimes exactly on it
        reach = $urandom_range(0, int'(drag_limit) * 3 / 2 + 2);
        if ($urandom_range(0, 7) == 0) begin
          off_x = int'(drag_limit);
          off_y = 0;
        end else begin
          off_x = reach;
          off_y = $urandom_range(0, reach / 2 + 1);
        end
        if ($urandom_range(0, 1)) begin
          r = off_x;
          off_x = off_y;
          off_y = r;
        end
        px = nudge(first_x[s], off_x);
        py = nudge(first_y[s], off_y);
      end
      send_touch(op, fid, px, py, stamp);
    end
    steady_stream = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    start        <= 1'b0;
    in_opcode    <= OP_QUERY;
    in_finger_id <= '0;
    in_pos_x     <= '0;
    in_pos_y     <= '0;
    in_stamp_ms  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_TIME_LIMIT;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    for (int i = 0; i < MAX_FINGERS; i++) finger_live[i] = 1'b0;
    wait_limit_ms = '0;
    drag_limit = '0;
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_instant_arm();
    test_unknown_fingers();
    test_full_table();
    test_candidate_limits();

    test_random_limits(16'd65535, 16'd65535, 140);
    test_random_limits(16'd100, 16'd1000, 140);
    test_random_limits(16'd0, 16'd30000, 140);
    test_random_limits(16'd2000, 16'd0, 140);
    test_random_limits(16'd65535, 16'd1, 140);
    test_random_limits(16'd1, 16'd65535, 140);
    test_random_limits(16'd250, 16'd400, 140);
    test_random_limits(LIMIT_W'($urandom), LIMIT_W'($urandom_range(1, 8000)), 140);

    drain_and_settle();
    $display("run covered %0d downs, %0d motions, %0d ups, %0d detaches, %0d fetches,",
             op_seen[OP_DOWN], op_seen[OP_MOTION], op_seen[OP_UP], op_seen[OP_DETACH],
             op_seen[OP_FETCH]);
    $display("%0d queries and %0d ticks over %0d limit settings; %0d reports compared",
             op_seen[OP_QUERY], op_seen[OP_TICK], limit_settings, reports_checked);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tjg_pkg.sv
rtl/tjg_front.sv
rtl/tjg_engine.sv
rtl/touch_joystick_gesture_tracker.sv
sim/tb_touch_joystick_gesture_tracker.sv
